>>> sv/positional_list_store_defines.svh
// ----------------------------------------------------------------------------
// positional list store assertion macros
// concurrent check helpers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property that must hold in every cycle out of reset
`define PLST_ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("plst check failed");
// consequent must hold in the cycle after the antecedent
`define PLST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("plst check failed");
`else
`define PLST_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define PLST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/plst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_pkg
// shared types, widths and codes of the positional list store
// ----------------------------------------------------------------------------
package plst_pkg;

	localparam int KIND_W       = 2;
	localparam int POS_W        = 5;
	localparam int VAL_W        = 32;
	localparam int ST_W         = 2;
	localparam int LEN_W        = 5;
	localparam int CAPACITY_DEF = 16;

	typedef logic signed [VAL_W-1:0] plst_val_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_READ   = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_DELETE = 2'd3
	} plst_kind_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} plst_status_t;

	// broadcast to every cell, at most one of ins/upd/del set
	typedef struct packed {
		logic             ins;
		logic             upd;
		logic             del;
		logic [POS_W-1:0] idx;
		plst_val_t        value;
	} plst_op_t;

endpackage

>>> sv/plst_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_req_if
// request channel: kind, position and value with valid/ready
// ----------------------------------------------------------------------------
interface plst_req_if;
	import plst_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [KIND_W-1:0]       kind;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, kind, position, value, input ready);
	modport sink   (input valid, kind, position, value, output ready);
endinterface

>>> sv/plst_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_rsp_if
// response channel: status, read value and list length with valid/ready
// ----------------------------------------------------------------------------
interface plst_rsp_if;
	import plst_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ST_W-1:0]         status;
	logic signed [VAL_W-1:0] read_value;
	logic [LEN_W-1:0]        list_length;

	modport source (output valid, status, read_value, list_length, input ready);
	modport sink   (input valid, status, read_value, list_length, output ready);
endinterface

>>> sv/plst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_cell
// one list slot: shifts from its neighbors on insert/delete, loads on write
// ----------------------------------------------------------------------------
module plst_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  plst_pkg::plst_op_t  op,
	input  plst_pkg::plst_val_t left_entry,
	input  plst_pkg::plst_val_t right_entry,
	output plst_pkg::plst_val_t entry,
	output plst_pkg::plst_val_t read_hit
);
	import plst_pkg::*;

	localparam logic [31:0] MY_IDX = 32'(IDX);

	plst_val_t entry_q;
	plst_val_t entry_nxt;
	logic      match;
	logic      after;

	assign match = (MY_IDX == 32'(op.idx));
	assign after = (MY_IDX > 32'(op.idx));

	always_comb begin
		entry_nxt = entry_q;
		if (op.ins) begin
			if (match) begin
				entry_nxt = op.value;
			end else if (after) begin
				entry_nxt = left_entry;
			end
		end else if (op.upd && match) begin
			entry_nxt = op.value;
		end else if (op.del && (match || after)) begin
			entry_nxt = right_entry;
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

	assign entry    = entry_q;
	assign read_hit = match ? entry_q : '0;

endmodule

>>> sv/positional_list_store.sv
`timescale 1ns / 1ps
// a request beat gives its response beat from a register, in the cycle after acceptance
// throughput: one request per cycle while responses are taken; every cell shifts in the same cycle
// a stalled response holds the output register and blocks new requests
// reset clears the entry count and the response valid flag
// the cell contents carry no reset; only written slots are ever read
// ----------------------------------------------------------------------------
// positional_list_store
// ordered list of signed 32-bit values addressed by 1-based position
// ----------------------------------------------------------------------------
module positional_list_store #(
	parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
	input logic      clk,
	input logic      arst_n,
	plst_req_if.sink   req,
	plst_rsp_if.source rsp
);
	import plst_pkg::*;

	`include "positional_list_store_defines.svh"

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// entry count and response register
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             rsp_valid_q;
	logic [ST_W-1:0]  status_q;
	plst_val_t        read_value_q;
	logic [LEN_W-1:0] length_q;

	// request decode
	plst_kind_t   kind;
	plst_status_t status;
	logic         fire;
	logic         pos_zero;
	logic         ins_bad_pos;
	logic         acc_bad_pos;
	logic         full;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	plst_op_t     op;
	plst_val_t    read_data;

	// the cell row
	plst_val_t entry_arr [CAPACITY];
	plst_val_t hit_arr   [CAPACITY];

	// response register frees up when its beat is taken
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign kind      = plst_kind_t'(req.kind);

	assign pos_ext     = CMP_W'(req.position);
	assign cnt_ext     = CMP_W'(count_q);
	assign pos_zero    = (req.position == '0);
	// insert may land one past the end, other kinds must hit a live entry
	assign ins_bad_pos = pos_zero || (pos_ext > (cnt_ext + CMP_W'(1)));
	assign acc_bad_pos = pos_zero || (pos_ext > cnt_ext);
	assign full        = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		op        = '0;
		op.idx    = req.position - POS_W'(1);
		op.value  = req.value;
		status    = ST_OK;
		count_nxt = count_q;
		unique case (kind)
			KIND_INSERT: begin
				// bad position wins over full
				if (ins_bad_pos) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					op.ins    = fire;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			KIND_READ: begin
				if (acc_bad_pos) status = ST_RANGE;
			end
			KIND_UPDATE: begin
				if (acc_bad_pos) begin
					status = ST_RANGE;
				end else begin
					op.upd = fire;
				end
			end
			KIND_DELETE: begin
				if (acc_bad_pos) begin
					status = ST_RANGE;
				end else begin
					op.del    = fire;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: status = ST_RANGE;
		endcase
	end

	// each cell takes from its left neighbor on insert, right on delete;
	// the end cells feed back their own value where no neighbor exists
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		plst_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.left_entry (entry_arr[(i == 0) ? 0 : i - 1]),
			.right_entry(entry_arr[(i == CAPACITY - 1) ? i : i + 1]),
			.entry      (entry_arr[i]),
			.read_hit   (hit_arr[i])
		);
	end

	// only the addressed cell drives a nonzero hit
	always_comb begin
		read_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			read_data = read_data | hit_arr[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q     <= status;
			read_value_q <= ((kind == KIND_READ) && (status == ST_OK)) ? read_data : '0;
			length_q     <= LEN_W'(count_nxt);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.list_length = length_q;

	`PLST_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY))
	`PLST_ASSERT_NEXT(a_insert_grows, clk, arst_n, fire && op.ins, count_q == $past(count_q) + CNT_W'(1))
	`PLST_ASSERT_NEXT(a_delete_shrinks, clk, arst_n, fire && op.del, count_q == $past(count_q) - CNT_W'(1))
	`PLST_ASSERT_NEXT(a_error_keeps, clk, arst_n, fire && (status != ST_OK), count_q == $past(count_q))
	`PLST_ASSERT_ALWAYS(a_read_only_ok, clk, arst_n, !rsp_valid_q || (read_value_q == '0) || (status_q == ST_OK))

endmodule

>>> tb/sv/plst_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_tb_pkg
// shadow copy of the positional list and the check of its response beats
// ----------------------------------------------------------------------------
package plst_tb_pkg;
	import plst_pkg::*;

	typedef struct {
		plst_status_t     status;
		plst_val_t        read_value;
		logic [LEN_W-1:0] list_length;
	} rsp_beat_t;

	class list_mirror;
		plst_val_t   slot [CAPACITY_DEF];
		int          entry_total;
		rsp_beat_t   pending_rsp_q [$];
		int unsigned error_count;
		int unsigned checked_count;
		int unsigned status_count [3];
		int          deepest;

		function new();
			foreach (slot[i]) slot[i] = '0;
			entry_total   = 0;
			error_count   = 0;
			checked_count = 0;
			deepest       = 0;
			foreach (status_count[i]) status_count[i] = 0;
		endfunction

		// apply one accepted request to the shadow list, queue its response
		function void note_request(plst_kind_t kind, logic [POS_W-1:0] position,
				plst_val_t value);
			rsp_beat_t beat;
			int        p;
			p               = int'(position);
			beat.status     = ST_OK;
			beat.read_value = '0;
			if (kind == KIND_INSERT) begin
				if (p < 1 || p > entry_total + 1) begin
					beat.status = ST_RANGE;
				end else if (entry_total >= CAPACITY_DEF) begin
					beat.status = ST_FULL;
				end else begin
					for (int i = entry_total; i > p - 1; i--) slot[i] = slot[i - 1];
					slot[p - 1] = value;
					entry_total++;
				end
			end else if (p < 1 || p > entry_total) begin
				beat.status = ST_RANGE;
			end else begin
				case (kind)
					KIND_READ: begin
						beat.read_value = slot[p - 1];
					end
					KIND_UPDATE: begin
						slot[p - 1] = value;
					end
					default: begin
						for (int i = p - 1; i + 1 < entry_total; i++) slot[i] = slot[i + 1];
						entry_total--;
					end
				endcase
			end
			beat.list_length = LEN_W'(entry_total);
			status_count[beat.status]++;
			if (entry_total > deepest) deepest = entry_total;
			pending_rsp_q.push_back(beat);
		endfunction

		task report_mismatch(string msg);
			error_count++;
			$display("ERROR @%0t: %s", $time, msg);
		endtask

		// compare one response beat against the oldest queued response
		task check_response(logic [ST_W-1:0] status, plst_val_t read_value,
				logic [LEN_W-1:0] list_length);
			rsp_beat_t want;
			if (pending_rsp_q.size() == 0) begin
				report_mismatch("response beat with no request outstanding");
				return;
			end
			want = pending_rsp_q.pop_front();
			checked_count++;
			if (status !== want.status)
				report_mismatch($sformatf("beat %0d status %0d, want %0d",
					checked_count, status, want.status));
			if (read_value !== want.read_value)
				report_mismatch($sformatf("beat %0d read_value %h, want %h",
					checked_count, read_value, want.read_value));
			if (list_length !== want.list_length)
				report_mismatch($sformatf("beat %0d list_length %0d, want %0d",
					checked_count, list_length, want.list_length));
		endtask
	endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the positional list store: a directed opening on
// the empty list and its edges, then phases of random requests that grow,
// shrink and churn the list, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb_top;
	import plst_pkg::*;
	import plst_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1550;
	localparam int LONG_HOLD    = 150;

	// phase flavors for the random part
	typedef enum int {
		MODE_GROW,
		MODE_SHRINK,
		MODE_MIXED,
		MODE_NOISE
	} phase_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	plst_req_if req_ch ();
	plst_rsp_if rsp_ch ();

	positional_list_store dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_mirror  mirror;
	int unsigned kind_count [4];
	int          rsp_hold_cycles = 0;  // one-shot long stall for the receiver
	bit          send_steady     = 1'b0;  // sender offers back to back
	bit          rsp_steady      = 1'b0;  // receiver always ready

	// 50 MHz clock
	always #10 clk = ~clk;

	// watchdog: far above the slowest legal run
	initial begin
		#(64'd20_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------

	// offer one request beat after a random gap, return at the edge it is taken
	task automatic send_request(input plst_kind_t kind, input logic [POS_W-1:0] position,
			input plst_val_t value);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.kind     <= kind;
		req_ch.position <= position;
		req_ch.value    <= value;
		// ready as seen just before the edge decides acceptance
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		mirror.note_request(kind, position, value);
		kind_count[kind]++;
	endtask

	// stop offering until every queued response has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (mirror.pending_rsp_q.size() != 0) @(posedge clk);
		// margin for anything late
		repeat (3) @(posedge clk);
	endtask

	// corner values half the time, otherwise any 32-bit pattern
	function automatic plst_val_t draw_value();
		case ($urandom_range(0, 7))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return plst_val_t'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// response side: random stalls, steady stretches, one long hold-off
	// ------------------------------------------------------------------------
	initial begin
		int stall;
		int beats_left;
		rsp_ch.ready <= 1'b0;
		beats_left = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (beats_left == 0) begin
				rsp_steady = ($urandom_range(0, 3) == 0);
				beats_left = $urandom_range(20, 60);
			end
			beats_left--;
			if (rsp_hold_cycles > 0) begin
				// long hold: output register fills, request side must stall
				stall           = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else begin
				stall = rsp_steady ? 0 : $urandom_range(0, 11);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			mirror.check_response(rsp_ch.status, rsp_ch.read_value, rsp_ch.list_length);
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		phase_mode_t      mode;
		plst_kind_t       kind;
		logic [POS_W-1:0] position;
		int               sent;
		int               phase;
		int               phase_len;
		int               len;
		int               roll;
		int               pick;

		mirror = new();
		foreach (kind_count[i]) kind_count[i] = 0;

		// every input known from time zero
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.kind     <= KIND_INSERT;
		req_ch.position <= '0;
		req_ch.value    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, the ends of the list, bad positions
		send_request(KIND_READ,   5'd1,  32'h0);          // read of empty list
		send_request(KIND_DELETE, 5'd1,  32'h0);          // delete one past the end
		send_request(KIND_UPDATE, 5'd1,  32'h1234_5678);  // update of empty list
		send_request(KIND_INSERT, 5'd0,  32'h1);          // zero position
		send_request(KIND_INSERT, 5'd2,  32'h1);          // insert past the end
		send_request(KIND_INSERT, 5'd1,  32'h7fff_ffff);  // first entry, max
		send_request(KIND_INSERT, 5'd2,  32'h8000_0000);  // append, min
		send_request(KIND_INSERT, 5'd1,  32'h0000_0000);  // insert at head
		send_request(KIND_INSERT, 5'd2,  32'hffff_ffff);  // insert in the middle
		send_request(KIND_READ,   5'd0,  32'h0);          // zero position read
		send_request(KIND_READ,   5'd4,  32'h0);          // last entry
		send_request(KIND_READ,   5'd1,  32'h0);          // first entry
		send_request(KIND_UPDATE, 5'd3,  32'h5555_5555);
		send_request(KIND_READ,   5'd3,  32'haaaa_aaaa);  // value field ignored
		send_request(KIND_DELETE, 5'd5,  32'h0);          // delete one past the end
		send_request(KIND_READ,   5'd31, 32'h0);          // all-ones position
		send_request(KIND_UPDATE, 5'd0,  32'h1);          // zero position update
		send_request(KIND_DELETE, 5'd2,  32'h0);          // close a middle gap
		send_request(KIND_READ,   5'd2,  32'h0);
		send_request(KIND_DELETE, 5'd3,  32'h0);          // drop the tail
		send_request(KIND_DELETE, 5'd1,  32'h0);          // drop the head
		send_request(KIND_INSERT, 5'd3,  32'h2);          // two past the end
		send_request(KIND_READ,   5'd1,  32'h0);
		send_request(KIND_DELETE, 5'd1,  32'h0);          // back to empty
		send_request(KIND_INSERT, 5'd17, 32'h3);          // far past the end
		wait_drained();

		// random phases: grow to full, shrink to empty, churn, and noise
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			pick        = $urandom_range(0, 9);
			mode        = (pick < 3) ? MODE_GROW : (pick < 6) ? MODE_SHRINK :
			              (pick < 9) ? MODE_MIXED : MODE_NOISE;
			phase_len   = $urandom_range(30, 90);
			send_steady = ($urandom_range(0, 3) == 0);
			// early on, force a long receiver stall under full request load
			if (phase == 2) begin
				send_steady     = 1'b1;
				rsp_hold_cycles = LONG_HOLD;
			end
			for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
				len  = mirror.entry_total;
				roll = $urandom_range(0, 99);
				if (mode == MODE_NOISE || roll < 8) begin
					// anything the fields can hold
					kind     = plst_kind_t'($urandom_range(0, 3));
					position = POS_W'($urandom_range(0, 31));
				end else begin
					pick = $urandom_range(0, 99);
					case (mode)
						MODE_GROW:   kind = (pick < 65) ? KIND_INSERT : (pick < 80) ? KIND_READ :
						                    (pick < 90) ? KIND_UPDATE : KIND_DELETE;
						MODE_SHRINK: kind = (pick < 15) ? KIND_INSERT : (pick < 30) ? KIND_READ :
						                    (pick < 40) ? KIND_UPDATE : KIND_DELETE;
						default:     kind = (pick < 30) ? KIND_INSERT : (pick < 55) ? KIND_READ :
						                    (pick < 75) ? KIND_UPDATE : KIND_DELETE;
					endcase
					if (roll < 14) begin
						// one or two past the last entry; the first is still legal for an insert
						position = POS_W'(len + 1 + $urandom_range(0, 1));
					end else if (kind == KIND_INSERT) begin
						// a legal position; in a full list it draws a list-full status
						position = POS_W'($urandom_range(1, len + 1));
					end else if (len == 0) begin
						position = POS_W'($urandom_range(0, 2));
					end else begin
						position = POS_W'($urandom_range(1, len));
					end
				end
				send_request(kind, position, draw_value());
				sent++;
			end
			// now and then let the sender sit idle until all responses are in
			if (phase % 4 == 3) wait_drained();
			phase++;
		end

		wait_drained();
		repeat (5) @(posedge clk);

		$display("covered %0d requests: %0d insert, %0d read, %0d update, %0d delete",
			mirror.checked_count, kind_count[KIND_INSERT], kind_count[KIND_READ],
			kind_count[KIND_UPDATE], kind_count[KIND_DELETE]);
		$display("outcomes: %0d ok, %0d out of range, %0d list full; deepest list %0d",
			mirror.status_count[ST_OK], mirror.status_count[ST_RANGE],
			mirror.status_count[ST_FULL], mirror.deepest);
		if (mirror.error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/plst_pkg.sv
sv/plst_req_if.sv
sv/plst_rsp_if.sv
sv/plst_cell.sv
sv/positional_list_store.sv
tb/sv/plst_tb_pkg.sv
tb/sv/tb_top.sv
